>>> src/fpfa_pkg.sv
// fpfa_pkg: shared types, widths and codes of the fixed-partition fit allocator
// used by fpfa_cell and fixed_partition_fit_allocator; no dependencies
package fpfa_pkg;

	// table geometry
	localparam int NBLOCKS   = 16;
	localparam int SIZE_BITS = 16;
	localparam int IDX_W     = $clog2(NBLOCKS);
	localparam int CNT_W     = 5;
	localparam int POL_W     = 2;
	localparam int CFG_W     = 5;

	// item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_REQ  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_ALLOC  = 2'd0;
	localparam logic [1:0] ST_NOFIT  = 2'd1;
	localparam logic [1:0] ST_LOADED = 2'd2;

	// policy codes; the unused code behaves as first fit
	localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POL_W-1:0] POL_WORST = 2'd2;

	// configuration register indexes
	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_BLOCKS = 1'b1;

	localparam logic [CNT_W-1:0] BLOCKS_RESET = CNT_W'(NBLOCKS);

	// input item
	typedef struct packed {
		logic                 func;
		logic [3:0]           block_index;
		logic [15:0]          request_size;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [1:0]           status;
		logic [3:0]           chosen_block;
	} out_item_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [IDX_W-1:0]     idx;
		logic [SIZE_BITS-1:0] left;
		logic [SIZE_BITS-1:0] want;
	} tok_t;

	// table update broadcast to all cells
	typedef struct packed {
		logic                 load;
		logic                 alloc;
		logic [IDX_W-1:0]     idx;
		logic [SIZE_BITS-1:0] size;
	} wr_cmd_t;

endpackage

>>> src/fixed_partition_fit_allocator.sv
// fixed_partition_fit_allocator: top level, row of fpfa_cell blocks, command and config ports
// depends on fpfa_pkg and fpfa_cell
//
//   channel   handshake           payload
//   input     start / busy        item   (in_item_t)
//   result    done strobe         result (out_item_t)
//   config    cfg_we              cfg_index, cfg_wdata
//
// a load item: done pulses in the cycle after it is accepted
// a request: the search token walks the row one cell per clock, then the winning
// block is written back and shown in the result registers
// busy is high while a request token is in the row; the next item may be
// accepted in the cycle that shows the result; results cannot be stalled
// arst_n clears the table to size zero and free, policy first fit, count NBLOCKS
module fixed_partition_fit_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  fpfa_pkg::in_item_t        item,
	output logic                      done,
	output fpfa_pkg::out_item_t       result,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [fpfa_pkg::CFG_W-1:0] cfg_wdata
);
	import fpfa_pkg::*;

	logic [POL_W-1:0] policy_q;
	logic [CNT_W-1:0] blocks_q;
	logic             search_q;
	logic             done_q;
	out_item_t        res_q;
	logic             accept;
	logic             load_acc;
	tok_t             chain [NBLOCKS+1];
	tok_t             tail;
	wr_cmd_t          wr_cmd;

	assign accept   = start && !busy;
	assign load_acc = accept && (item.func == FUNC_LOAD);
	assign busy     = search_q;
	assign tail     = chain[NBLOCKS];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
			blocks_q <= BLOCKS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLICY: policy_q <= cfg_wdata[POL_W-1:0];
				REG_BLOCKS: blocks_q <= cfg_wdata[CNT_W-1:0];
				default:    ;
			endcase
		end
	end

	// a request enters the row as a fresh token
	always_comb begin
		chain[0]       = '0;
		chain[0].valid = accept && (item.func == FUNC_REQ);
		chain[0].want  = SIZE_BITS'(item.request_size);
	end

	// table update: load on accept, allocation when the token leaves the row
	always_comb begin
		wr_cmd = '0;
		if (load_acc) begin
			wr_cmd.load = 1'b1;
			wr_cmd.idx  = IDX_W'(item.block_index);
			wr_cmd.size = SIZE_BITS'(item.request_size);
		end else begin
			wr_cmd.alloc = tail.valid && tail.found;
			wr_cmd.idx   = tail.idx;
			wr_cmd.size  = tail.want;
		end
	end

	// row of cells
	for (genvar i = 0; i < NBLOCKS; i++) begin : g_cell
		fpfa_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cell_idx      (IDX_W'(i)),
			.policy        (policy_q),
			.blocks_in_use (blocks_q),
			.wr_cmd        (wr_cmd),
			.tok_in        (chain[i]),
			.tok_out       (chain[i+1])
		);
	end

	// request in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_q <= 1'b0;
		end else if (chain[0].valid) begin
			search_q <= 1'b1;
		end else if (tail.valid) begin
			search_q <= 1'b0;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= load_acc || tail.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_acc) begin
			res_q.status       <= ST_LOADED;
			res_q.chosen_block <= '0;
		end else if (tail.valid && tail.found) begin
			res_q.status       <= ST_ALLOC;
			res_q.chosen_block <= 4'(tail.idx);
		end else if (tail.valid) begin
			res_q.status       <= ST_NOFIT;
			res_q.chosen_block <= '0;
		end
	end

	assign done   = done_q;
	assign result = res_q;

`ifndef NO_ASSERTIONS
	// an accepted load answers in the next cycle
	a_load_resp: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> done && (result.status == ST_LOADED))
		else $error("load item without loaded result");

	// an accepted request holds off further items
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chain[0].valid |=> busy)
		else $error("request accepted but block not busy");

	// a token only reaches the end of the row while a request is open
	a_tail_open: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> search_q)
		else $error("search token with no open request");

	// only an allocation names a block
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_ALLOC)) |-> (result.chosen_block == 4'd0))
		else $error("block index on a non-allocation result");

	// allocated block lies within the searched range
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_ALLOC)) |-> (CNT_W'(result.chosen_block) < blocks_q))
		else $error("allocated block outside searched range");
`endif

endmodule

>>> src/fpfa_cell.sv
// fpfa_cell: one table block (size and taken flag) plus one stage of the search row
// depends on fpfa_pkg
module fpfa_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [fpfa_pkg::IDX_W-1:0]   cell_idx,
	input  logic [fpfa_pkg::POL_W-1:0]   policy,
	input  logic [fpfa_pkg::CNT_W-1:0]   blocks_in_use,
	input  fpfa_pkg::wr_cmd_t            wr_cmd,
	input  fpfa_pkg::tok_t               tok_in,
	output fpfa_pkg::tok_t               tok_out
);
	import fpfa_pkg::*;

	logic [SIZE_BITS-1:0] size_q;
	logic                 taken_q;
	logic                 active;
	logic                 fits;
	logic [SIZE_BITS-1:0] left;
	logic                 better;
	logic                 take;
	logic                 hit;
	tok_t                 tok_q;

	// block takes part only below the configured count
	assign active = CNT_W'(cell_idx) < blocks_in_use;
	assign fits   = active && !taken_q && (size_q >= tok_in.want);
	assign left   = size_q - tok_in.want;

	// compare against the candidate carried so far; ties keep the lower index
	always_comb begin
		case (policy)
			POL_BEST:  better = left < tok_in.left;
			POL_WORST: better = left > tok_in.left;
			default:   better = 1'b0;
		endcase
	end

	assign take = tok_in.valid && fits && (!tok_in.found || better);
	assign hit  = wr_cmd.idx == cell_idx;

	// block state: load writes a fresh free block, allocation shrinks and marks it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= '0;
			taken_q <= 1'b0;
		end else if (wr_cmd.load && hit) begin
			size_q  <= wr_cmd.size;
			taken_q <= 1'b0;
		end else if (wr_cmd.alloc && hit) begin
			size_q  <= size_q - wr_cmd.size;
			taken_q <= 1'b1;
		end
	end

	// pass the token on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.found <= tok_in.found || take;
			tok_q.idx   <= take ? cell_idx : tok_in.idx;
			tok_q.left  <= take ? left : tok_in.left;
			tok_q.want  <= tok_in.want;
		end
	end

	assign tok_out = tok_q;

endmodule
